// File: rtl/bstv_pkg.sv
// shared constants, types and helpers for the bst in-order validator
package bstv_pkg;

  localparam int MAX_NODES  = 1024;
  localparam int IDX_BITS   = $clog2(MAX_NODES);
  localparam int CNT_BITS   = $clog2(MAX_NODES + 1);
  localparam int KEY_BITS   = 32;
  localparam int CHILD_BITS = 11;

  // walk sequencer states
  typedef enum logic [2:0] {
    S_LOAD,
    S_DESC,
    S_LEFT,
    S_POP,
    S_VISIT
  } state_t;

  // one stored tree node
  typedef struct packed {
    logic signed [KEY_BITS-1:0] key;
    logic [CHILD_BITS-1:0]      left;
    logic [CHILD_BITS-1:0]      right;
  } node_t;

  // stack control from the sequencer
  typedef struct packed {
    logic clear;
    logic push;
    logic pop;
  } stack_cmd_t;

  // stack status back to the sequencer
  typedef struct packed {
    logic empty;
    logic full;
  } stack_stat_t;

  // child index to slot, MAX_NODES when negative or not loaded
  function automatic logic [CNT_BITS-1:0] child_slot(
    input logic [CHILD_BITS-1:0] raw,
    input logic [CNT_BITS-1:0]   count
  );
    logic [CNT_BITS-1:0] v;
    v = CNT_BITS'(raw[CHILD_BITS-2:0]);
    if (raw[CHILD_BITS-1] || (v >= count)) begin
      return CNT_BITS'(MAX_NODES);
    end
    return v;
  endfunction

endpackage

// File: rtl/bstv_stack.sv
// walk stack: node index memory with a depth pointer, registered pop data
module bstv_stack (
  input  logic                          clk,
  input  logic                          rst,
  input  bstv_pkg::stack_cmd_t          cmd,
  input  logic [bstv_pkg::IDX_BITS-1:0] push_data,
  output logic [bstv_pkg::IDX_BITS-1:0] pop_data,
  output bstv_pkg::stack_stat_t         stat
);

  logic [bstv_pkg::IDX_BITS-1:0] mem [bstv_pkg::MAX_NODES];
  logic [bstv_pkg::CNT_BITS-1:0] depth;
  logic [bstv_pkg::CNT_BITS-1:0] depth_dec;

  assign depth_dec = depth - bstv_pkg::CNT_BITS'(1);

  // status flags
  always_comb begin
    stat.empty = (depth == '0);
    stat.full  = (depth == bstv_pkg::CNT_BITS'(bstv_pkg::MAX_NODES));
  end

  // depth pointer
  always_ff @(posedge clk) begin
    if (rst || cmd.clear) begin
      depth <= '0;
    end else if (cmd.push) begin
      depth <= depth + bstv_pkg::CNT_BITS'(1);
    end else if (cmd.pop) begin
      depth <= depth_dec;
    end
  end

  // stack memory, one write or one read a cycle
  always_ff @(posedge clk) begin
    if (cmd.push) begin
      mem[depth[bstv_pkg::IDX_BITS-1:0]] <= push_data;
    end
    if (cmd.pop) begin
      pop_data <= mem[depth_dec[bstv_pkg::IDX_BITS-1:0]];
    end
  end

endmodule

// File: rtl/bst_inorder_validator.sv
// top level: node load into memory and in-order walk sequencer
//
//  channel | handshake            | payload
//  --------+----------------------+------------------------------------------
//  in      | in_valid / in_ready  | is_empty node_key left_child right_child
//          |                      | last_node
//  out     | out_valid / out_ready| tree_is_valid
//
// a node word loads into node memory when accepted; an empty word gives its result the next cycle
// after the last node the walk passes S_DESC and S_LEFT for each left descent and S_DESC,
// S_POP and S_VISIT for each visited node (stack read, node memory read, compare)
// in_ready is low during the walk and while an unread result waits
// synchronous reset clears the sequencer, counts and the result valid flag;
// the node and stack memories hold no reset value
module bst_inorder_validator (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic                                is_empty,
  input  logic signed [bstv_pkg::KEY_BITS-1:0] node_key,
  input  logic signed [bstv_pkg::CHILD_BITS-1:0] left_child,
  input  logic signed [bstv_pkg::CHILD_BITS-1:0] right_child,
  input  logic                                last_node,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic                                tree_is_valid
);

  bstv_pkg::state_t              state, state_next;
  bstv_pkg::node_t               node_mem [bstv_pkg::MAX_NODES];
  bstv_pkg::node_t               node_rdata;
  logic [bstv_pkg::IDX_BITS-1:0] node_raddr;
  logic [bstv_pkg::CNT_BITS-1:0] loaded_count;
  logic [bstv_pkg::CNT_BITS-1:0] cur, cur_next;
  logic signed [bstv_pkg::KEY_BITS-1:0] prev_key;
  logic                          prev_seen;
  logic                          cur_valid;
  logic                          in_accept;
  logic                          done;
  logic                          done_ok;
  logic                          visit_ok;
  bstv_pkg::stack_cmd_t          stk_cmd;
  bstv_pkg::stack_stat_t         stk_stat;
  logic [bstv_pkg::IDX_BITS-1:0] stk_pop_data;

  assign in_ready  = (state == bstv_pkg::S_LOAD) && (!out_valid || out_ready);
  assign in_accept = in_valid && in_ready;
  assign cur_valid = (cur < bstv_pkg::CNT_BITS'(bstv_pkg::MAX_NODES));
  assign visit_ok  = !prev_seen || (node_rdata.key > prev_key);

  // walk stack
  bstv_stack u_stack (
    .clk       (clk),
    .rst       (rst),
    .cmd       (stk_cmd),
    .push_data (cur[bstv_pkg::IDX_BITS-1:0]),
    .pop_data  (stk_pop_data),
    .stat      (stk_stat)
  );

  // next state
  always_comb begin
    state_next = state;
    case (state)
      bstv_pkg::S_LOAD: begin
        if (in_accept && !is_empty && last_node) begin
          state_next = bstv_pkg::S_DESC;
        end
      end
      bstv_pkg::S_DESC: begin
        if (cur_valid && !stk_stat.full) begin
          state_next = bstv_pkg::S_LEFT;
        end else if (cur_valid || stk_stat.empty) begin
          state_next = bstv_pkg::S_LOAD;
        end else begin
          state_next = bstv_pkg::S_POP;
        end
      end
      bstv_pkg::S_LEFT:  state_next = bstv_pkg::S_DESC;
      bstv_pkg::S_POP:   state_next = bstv_pkg::S_VISIT;
      bstv_pkg::S_VISIT: state_next = visit_ok ? bstv_pkg::S_DESC : bstv_pkg::S_LOAD;
      default:           state_next = bstv_pkg::S_LOAD;
    endcase
  end

  // sequencer outputs: stack commands, node read address, walk result
  always_comb begin
    stk_cmd    = '0;
    node_raddr = cur[bstv_pkg::IDX_BITS-1:0];
    cur_next   = cur;
    done       = 1'b0;
    done_ok    = 1'b0;
    case (state)
      bstv_pkg::S_LOAD: begin
        if (in_accept && !is_empty && last_node) begin
          stk_cmd.clear = 1'b1;
          cur_next      = '0;
        end
      end
      bstv_pkg::S_DESC: begin
        if (cur_valid) begin
          if (stk_stat.full) begin
            done = 1'b1;
          end else begin
            stk_cmd.push = 1'b1;
          end
        end else if (stk_stat.empty) begin
          done    = 1'b1;
          done_ok = 1'b1;
        end else begin
          stk_cmd.pop = 1'b1;
        end
      end
      bstv_pkg::S_LEFT: begin
        cur_next = bstv_pkg::child_slot(node_rdata.left, loaded_count);
      end
      bstv_pkg::S_POP: begin
        node_raddr = stk_pop_data;
      end
      bstv_pkg::S_VISIT: begin
        if (visit_ok) begin
          cur_next = bstv_pkg::child_slot(node_rdata.right, loaded_count);
        end else begin
          done = 1'b1;
        end
      end
      default: begin
        done = 1'b0;
      end
    endcase
  end

  // node memory: load writes, walk reads through a registered read port
  always_ff @(posedge clk) begin
    if (in_accept && !is_empty &&
        (loaded_count < bstv_pkg::CNT_BITS'(bstv_pkg::MAX_NODES))) begin
      node_mem[loaded_count[bstv_pkg::IDX_BITS-1:0]] <= '{
        key:   node_key,
        left:  left_child,
        right: right_child
      };
    end
    node_rdata <= node_mem[node_raddr];
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= bstv_pkg::S_LOAD;
      loaded_count <= '0;
      cur          <= '0;
      prev_seen    <= 1'b0;
      out_valid    <= 1'b0;
    end else begin
      state <= state_next;
      cur   <= cur_next;
      // result flag: a new result takes over from the one just read
      if ((in_accept && is_empty) || done) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      if (in_accept) begin
        if (is_empty) begin
          loaded_count <= '0;
        end else begin
          if (loaded_count < bstv_pkg::CNT_BITS'(bstv_pkg::MAX_NODES)) begin
            loaded_count <= loaded_count + bstv_pkg::CNT_BITS'(1);
          end
          if (last_node) begin
            prev_seen <= 1'b0;
          end
        end
      end
      if (state == bstv_pkg::S_VISIT && visit_ok) begin
        prev_seen <= 1'b1;
      end
      if (done) begin
        loaded_count <= '0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (state == bstv_pkg::S_VISIT && visit_ok) begin
      prev_key <= node_rdata.key;
    end
    if (in_accept && is_empty) begin
      tree_is_valid <= 1'b1;
    end else if (done) begin
      tree_is_valid <= done_ok;
    end
  end

endmodule

// File: rtl/bstv_checker.sv
// port-level checker for the bst in-order validator, with its bind
module bstv_checker (
  input logic clk,
  input logic rst,
  input logic in_valid,
  input logic in_ready,
  input logic is_empty,
  input logic last_node,
  input logic out_valid,
  input logic out_ready,
  input logic tree_is_valid
);

  // a waiting result word holds its value
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(tree_is_valid))
    else $error("result word changed while stalled");

  // an empty word yields a valid result on the next cycle
  a_empty_result: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && is_empty |=> out_valid && tree_is_valid)
    else $error("empty word did not give a valid result");

  // the last node starts a walk, so input closes
  a_walk_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && !is_empty && last_node |=> !in_ready && !out_valid)
    else $error("input open right after the last node");

  // no new word while a result waits unread
  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |-> !in_ready)
    else $error("input ready while a result waits");

endmodule

bind bst_inorder_validator bstv_checker u_bstv_checker (
  .clk           (clk),
  .rst           (rst),
  .in_valid      (in_valid),
  .in_ready      (in_ready),
  .is_empty      (is_empty),
  .last_node     (last_node),
  .out_valid     (out_valid),
  .out_ready     (out_ready),
  .tree_is_valid (tree_is_valid)
);

// File: sim/tb_bst_inorder_validator.sv
// testbench for bst_inorder_validator: random and directed trees checked against an in-order walk
`timescale 1ns / 100ps

module tb_bst_inorder_validator;

  localparam int NODES       = bstv_pkg::MAX_NODES;
  localparam int KB          = bstv_pkg::KEY_BITS;
  localparam int CB          = bstv_pkg::CHILD_BITS;
  localparam int STALL_LIMIT = 20000;
  localparam int TAIL_CYCLES = 20;
  localparam int RANDOM_WORDS = 920;
  localparam int CHAIN_WORDS = 200;
  localparam int KEY_LO      = 32'sh8000_0000;
  localparam int KEY_HI      = 32'sh7FFF_FFFF;
  localparam logic [CB-1:0] NO_CHILD  = '1;
  localparam logic [CB-1:0] NEG_CHILD = 11'h7FE;
  localparam logic [CB-1:0] BIG_CHILD = 11'h400;

  // one input word as the driver presents it
  typedef struct {
    bit                   empty;
    logic signed [KB-1:0] key;
    logic [CB-1:0]        lchild;
    logic [CB-1:0]        rchild;
    bit                   is_last;
    bit                   drain;
    bit                   steady;
  } node_word_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic                 is_empty = 1'b0;
  logic signed [KB-1:0] node_key = '0;
  logic signed [CB-1:0] left_child = '0;
  logic signed [CB-1:0] right_child = '0;
  logic                 last_node = 1'b0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic                 tree_is_valid;

  bst_inorder_validator dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .is_empty(is_empty),
    .node_key(node_key),
    .left_child(left_child),
    .right_child(right_child),
    .last_node(last_node),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .tree_is_valid(tree_is_valid)
  );

  // clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  node_word_t pending_q[$];
  bit         verdict_q[$];
  bit         word_taken = 1'b0;
  bit         steady = 1'b0;
  int         stall_cycles = 0;
  int         mismatches = 0;
  int         words_in = 0;
  int         trees_ok = 0;
  int         trees_bad = 0;

  // mirror of the node memory and walk stack
  logic signed [KB-1:0] key_mem[NODES];
  logic [CB-1:0]        left_mem[NODES];
  logic [CB-1:0]        right_mem[NODES];
  int                   walk_trail[NODES];
  int                   nodes_held = 0;

  // tree generation scratch
  int            g_key[NODES];
  int            g_left[NODES];
  int            g_right[NODES];
  int            perm[NODES];
  int            inv[NODES];
  int            s_key[NODES];
  logic [CB-1:0] s_left[NODES];
  logic [CB-1:0] s_right[NODES];

  // raw child index to slot, NODES when absent or not loaded
  function automatic int slot_or_none(logic [CB-1:0] raw);
    if (raw[CB-1] || int'(raw) >= nodes_held) begin
      return NODES;
    end
    return int'(raw);
  endfunction

  // in-order walk over the mirrored tree, 1 when keys strictly increase
  function automatic bit order_holds();
    int                   cur;
    int                   depth;
    bit                   seen;
    logic signed [KB-1:0] prev;
    cur   = 0;
    depth = 0;
    seen  = 1'b0;
    prev  = '0;
    while (cur < NODES || depth > 0) begin
      while (cur < NODES) begin
        if (depth >= NODES) begin
          return 1'b0;
        end
        walk_trail[depth] = cur;
        depth++;
        cur = slot_or_none(left_mem[cur]);
      end
      depth--;
      cur = walk_trail[depth];
      if (seen && key_mem[cur] <= prev) begin
        return 1'b0;
      end
      prev = key_mem[cur];
      seen = 1'b1;
      cur  = slot_or_none(right_mem[cur]);
    end
    return 1'b1;
  endfunction

  task automatic push_word(input bit empty, input int key, input logic [CB-1:0] lc,
                           input logic [CB-1:0] rc, input bit is_last, input bit drain,
                           input bit stdy);
    node_word_t w;
    w.empty   = empty;
    w.key     = key;
    w.lchild  = lc;
    w.rchild  = rc;
    w.is_last = is_last;
    w.drain   = drain;
    w.steady  = stdy;
    pending_q.insert(pending_q.size(), w);
  endtask

  task automatic report_mismatch(input string what, input int want, input int got);
    mismatches++;
    if (mismatches <= 10) begin
      $display("mismatch %0d at %0t: %s, expected %0d got %0d",
               mismatches, $time, what, want, got);
    end
  endtask

  // build a search tree by insertion, scatter it over slots, maybe corrupt it
  task automatic queue_random_tree(input int n, input bit drain, input bit stdy);
    int  shape;
    bit  narrow;
    int  base;
    int  stride;
    int  p;
    int  j;
    int  tmp;
    int  s;
    int  t;
    int  c;
    int  cut;
    bit  placed;
    shape  = $urandom_range(0, 9);
    narrow = ($urandom_range(0, 3) == 0);
    base   = int'($urandom);
    stride = $urandom_range(1, 1000);
    for (int i = 0; i < n; i++) begin
      if (shape < 7) begin
        g_key[i] = narrow ? int'($urandom_range(0, 15)) - 8 : int'($urandom);
      end else if (shape < 9) begin
        g_key[i] = base + i * stride;
      end else begin
        g_key[i] = base - i * stride;
      end
      g_left[i]  = -1;
      g_right[i] = -1;
      p      = 0;
      placed = (i == 0);
      while (!placed) begin
        if (g_key[i] < g_key[p]) begin
          if (g_left[p] < 0) begin
            g_left[p] = i;
            placed = 1'b1;
          end else begin
            p = g_left[p];
          end
        end else begin
          if (g_right[p] < 0) begin
            g_right[p] = i;
            placed = 1'b1;
          end else begin
            p = g_right[p];
          end
        end
      end
    end
    // shuffle slots, root stays at slot 0
    for (int i = 0; i < n; i++) begin
      perm[i] = i;
    end
    for (int i = n - 1; i >= 2; i--) begin
      j = $urandom_range(1, i);
      tmp = perm[i];
      perm[i] = perm[j];
      perm[j] = tmp;
    end
    for (int i = 0; i < n; i++) begin
      inv[perm[i]] = i;
    end
    for (int k = 0; k < n; k++) begin
      j = inv[k];
      s_key[k]   = g_key[j];
      s_left[k]  = (g_left[j] < 0) ? NO_CHILD : CB'(perm[g_left[j]]);
      s_right[k] = (g_right[j] < 0) ? NO_CHILD : CB'(perm[g_right[j]]);
    end
    // damage
    s = $urandom_range(0, n - 1);
    t = $urandom_range(0, n - 1);
    c = $urandom_range(0, 99);
    if (c < 55) begin
      // keep as built
    end else if (c < 65) begin
      tmp = s_key[s];
      s_key[s] = s_key[t];
      s_key[t] = tmp;
    end else if (c < 72) begin
      s_key[s] = s_key[t];
    end else if (c < 80) begin
      if ($urandom_range(0, 1)) s_left[s] = CB'($urandom_range(0, 2047));
      else s_right[s] = CB'($urandom_range(0, 2047));
    end else if (c < 88) begin
      if ($urandom_range(0, 1)) s_left[s] = CB'(t);
      else s_right[s] = CB'(t);
    end else if (c < 94) begin
      s_left[s] = CB'(s);
    end else begin
      s_key[s] = $urandom_range(0, 1) ? KEY_LO : KEY_HI;
    end
    // occasional empty word in mid-load throws away what came before
    cut = (n > 1 && $urandom_range(0, 24) == 0) ? $urandom_range(0, n - 2) : -1;
    for (int k = 0; k < n; k++) begin
      push_word(1'b0, s_key[k], s_left[k], s_right[k], k == n - 1, drain && k == 0, stdy);
      if (k == cut) begin
        push_word(1'b1, int'($urandom), CB'($urandom_range(0, 2047)),
                  CB'($urandom_range(0, 2047)), $urandom_range(0, 1), 1'b0, stdy);
      end
    end
  endtask

  // driver: new word at the falling edge once the previous one was taken
  always @(negedge clk) begin
    node_word_t w;
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || word_taken) begin
      if (pending_q.size() != 0 && !(pending_q[0].drain && verdict_q.size() != 0) &&
          (pending_q[0].steady || $urandom_range(0, 99) >= 35)) begin
        w = pending_q.pop_front();
        is_empty    <= w.empty;
        node_key    <= w.key;
        left_child  <= w.lchild;
        right_child <= w.rchild;
        last_node   <= w.is_last;
        steady      <= w.steady;
        in_valid    <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // result side back-pressure
  always @(negedge clk) begin
    out_ready <= steady || ($urandom_range(0, 99) >= 35);
  end

  // monitor: predict on accepted words, check accepted verdicts
  always @(posedge clk) begin
    bit want;
    if (rst) begin
      word_taken   <= 1'b0;
      stall_cycles <= 0;
    end else begin
      word_taken <= in_valid && in_ready;
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        stall_cycles <= 0;
      end else begin
        stall_cycles <= stall_cycles + 1;
      end
      if (in_valid && in_ready) begin
        words_in++;
        if (is_empty) begin
          nodes_held = 0;
          verdict_q.insert(verdict_q.size(), 1'b1);
        end else begin
          if (nodes_held < NODES) begin
            key_mem[nodes_held]   = node_key;
            left_mem[nodes_held]  = left_child;
            right_mem[nodes_held] = right_child;
            nodes_held++;
          end
          if (last_node) begin
            verdict_q.insert(verdict_q.size(), order_holds());
            nodes_held = 0;
          end
        end
      end
      if (out_valid && out_ready) begin
        if (verdict_q.size() == 0) begin
          report_mismatch("verdict with none outstanding", -1, tree_is_valid);
        end else begin
          want = verdict_q.pop_front();
          if (tree_is_valid !== want) begin
            report_mismatch("tree_is_valid", want, tree_is_valid);
          end
          if (want) trees_ok++;
          else trees_bad++;
        end
      end
    end
  end

  // watchdog on handshake activity
  initial begin
    while (stall_cycles < STALL_LIMIT) @(posedge clk);
    $display("watchdog: no handshake for %0d cycles, %0d verdicts outstanding",
             STALL_LIMIT, verdict_q.size());
    $display("[FAIL] regression broken");
    $finish;
  end

  // stimulus and end of run
  initial begin
    int sent;
    int n;
    int c;
    bit big_done;
    bit first;

    // directed: empties, extreme keys, bad links, discards
    push_word(1'b1, 0, '0, '0, 1'b0, 1'b0, 1'b0);
    push_word(1'b1, -1, NO_CHILD, NO_CHILD, 1'b1, 1'b0, 1'b0);
    push_word(1'b0, KEY_LO, NO_CHILD, NO_CHILD, 1'b1, 1'b0, 1'b0);
    // left link to itself overflows the walk stack
    push_word(1'b0, KEY_HI, 11'd0, NO_CHILD, 1'b1, 1'b0, 1'b0);
    push_word(1'b0, KEY_HI, 11'd1, NO_CHILD, 1'b0, 1'b0, 1'b0);
    push_word(1'b0, KEY_LO, NO_CHILD, NO_CHILD, 1'b1, 1'b0, 1'b0);
    push_word(1'b0, KEY_LO, NO_CHILD, 11'd1, 1'b0, 1'b0, 1'b0);
    push_word(1'b0, KEY_HI, NO_CHILD, NO_CHILD, 1'b1, 1'b0, 1'b0);
    // equal keys
    push_word(1'b0, 5, NO_CHILD, 11'd1, 1'b0, 1'b0, 1'b0);
    push_word(1'b0, 5, NO_CHILD, NO_CHILD, 1'b1, 1'b0, 1'b0);
    // left child larger than parent
    push_word(1'b0, 0, 11'd1, NO_CHILD, 1'b0, 1'b0, 1'b0);
    push_word(1'b0, 1, NO_CHILD, NO_CHILD, 1'b1, 1'b0, 1'b0);
    // children outside the loaded range
    push_word(1'b0, 9, 11'd1023, NEG_CHILD, 1'b1, 1'b0, 1'b0);
    push_word(1'b0, 9, NO_CHILD, 11'd1, 1'b1, 1'b0, 1'b0);
    push_word(1'b0, KEY_LO, NO_CHILD, BIG_CHILD, 1'b1, 1'b0, 1'b0);
    // loaded node dropped by an empty word
    push_word(1'b0, 3, NO_CHILD, NO_CHILD, 1'b0, 1'b0, 1'b0);
    push_word(1'b1, 0, '0, '0, 1'b0, 1'b0, 1'b0);
    push_word(1'b0, 4, NO_CHILD, NO_CHILD, 1'b1, 1'b0, 1'b0);
    // right link to itself, and a shared child
    push_word(1'b0, 2, NO_CHILD, 11'd0, 1'b1, 1'b0, 1'b0);
    push_word(1'b0, 10, 11'd1, 11'd1, 1'b0, 1'b0, 1'b0);
    push_word(1'b0, 5, NO_CHILD, NO_CHILD, 1'b1, 1'b0, 1'b0);

    // random trees, first one waits for the directed verdicts to drain
    sent = 0;
    big_done = 1'b0;
    first = 1'b1;
    while (sent < RANDOM_WORDS) begin
      if (!big_done && sent >= 500) begin
        // long left chain, keys falling with depth, last link past the end
        for (int i = 0; i < CHAIN_WORDS; i++) begin
          push_word(1'b0, 1000000 - i * 7, CB'(i + 1), NO_CHILD, i == CHAIN_WORDS - 1,
                    i == 0, 1'b0);
        end
        sent += CHAIN_WORDS;
        big_done = 1'b1;
      end
      c = $urandom_range(0, 99);
      if (c < 4) begin
        push_word(1'b1, int'($urandom), CB'($urandom_range(0, 2047)),
                  CB'($urandom_range(0, 2047)), $urandom_range(0, 1), 1'b0,
                  sent >= 250 && sent < 400);
        sent++;
      end else begin
        c = $urandom_range(0, 99);
        n = (c < 75) ? $urandom_range(1, 8) :
            (c < 96) ? $urandom_range(9, 40) : $urandom_range(41, 120);
        queue_random_tree(n, first || $urandom_range(0, 19) == 0,
                          sent >= 250 && sent < 400);
        first = 1'b0;
        sent += n;
      end
    end

    repeat (11) @(posedge clk);
    @(negedge clk) rst <= 1'b0;

    while (pending_q.size() != 0 || in_valid || verdict_q.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("covered %0d node words and %0d tree verdicts (%0d ordered, %0d broken)",
             words_in, trees_ok + trees_bad, trees_ok, trees_bad);
    $display("verdict mismatches: %0d", mismatches);
    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
